[design/tsts_pkg.sv]
package tsts_pkg;

	localparam int NUM_SLOTS_DEF  = 16;
	localparam int TIME_WIDTH_DEF = 32;

	localparam logic [1:0] ACT_ADD    = 2'd0;
	localparam logic [1:0] ACT_REMOVE = 2'd1;
	localparam logic [1:0] ACT_MODIFY = 2'd2;
	localparam logic [1:0] ACT_SCAN   = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_INACTIVE = 2'd2;

	// per-slot decision of the evaluation unit
	typedef struct packed {
		logic fire;
		logic wr_dl;
		logic wr_per;
		logic wr_rep;
		logic act_next;
	} slot_ctl_t;

endpackage

[design/timer_slot_table_scan_top.sv]
// Timer slot table. Each input transaction is one command: add, remove,
// modify period or scan. s_tuser carries the command, s_tdata its operands.
// Every command walks the whole table once, one slot per cycle through a
// shared evaluation unit (compare, add, subtract) unless a scan result is
// held up by the receiver; s_tready stays low from acceptance to the final
// result, and the next command is taken in the cycle after the final
// result is loaded into the output register.
// Results leave through a single output register on the m_ group. Add,
// remove and modify give one result; a scan gives one result per expired
// slot (or one if none expired), and m_tlast marks the final one, which also
// carries the earliest remaining deadline and the wait until it.
// If the receiver stalls while a scan still has results to hand over, the
// walk pauses in place until the output register frees up; nothing is lost.
// Reset clears all slots to inactive; no clearing pass is needed.
module timer_slot_table_scan_top
	import tsts_pkg::*;
#(
	parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
	parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [3:0] slot_id, [19:4] repeat_count, [51:20] period_ms, [83:52] now_ms
	input  logic [87:0]  s_tdata,
	// [1:0] action
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [3:0] result_slot, [35:4] lateness_ms, [36] timeout_valid,
	// [68:37] next_deadline, [100:69] wait_ms
	output logic [103:0] m_tdata,
	// [1:0] status, [2] fired
	output logic [2:0]   m_tuser,
	output logic         m_tlast
);

	localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CW = $clog2(NUM_SLOTS + 1);
	localparam int TW = TIME_WIDTH;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_WALK = 3'b010,
		S_FIN  = 3'b100
	} state_t;

	state_t state_q;

	// slot storage
	logic [TW-1:0] period_mem   [NUM_SLOTS];
	logic [TW-1:0] deadline_mem [NUM_SLOTS];
	logic [15:0]   repeats_mem  [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] active_q;

	// latched command
	logic [1:0]    action_q;
	logic [SW-1:0] id_q;
	logic          ok_q;
	logic [15:0]   count_q;
	logic [TW-1:0] period_q;
	logic [TW-1:0] now_q;

	// walk pipeline
	logic [CW-1:0] rd_cnt_q;
	logic          v_s1;
	logic [SW-1:0] idx_s1;
	logic [TW-1:0] period_s1;
	logic [TW-1:0] dl_s1;
	logic [15:0]   rep_s1;
	logic          v_s2;
	logic          act_s2;
	logic [TW-1:0] dl_s2;

	logic          found_q;
	logic [SW-1:0] alloc_slot_q;
	logic          any_q;
	logic [TW-1:0] best_q;
	logic          pend_q;
	logic [3:0]    pend_slot_q;
	logic [31:0]   pend_late_q;

	// output register
	logic         out_valid_q;
	logic [1:0]   o_status_q;
	logic [3:0]   o_slot_q;
	logic         o_fired_q;
	logic [31:0]  o_late_q;
	logic         o_tv_q;
	logic [31:0]  o_next_q;
	logic [31:0]  o_wait_q;
	logic         o_last_q;

	logic          accept;
	logic          out_free;
	logic          done_issue;
	logic          hit;
	logic          alloc;
	logic          emit_fire;
	logic          adv;
	logic [SW-1:0] s_id_idx;
	logic          s_id_ok;
	logic [TW-1:0] wait_full;

	slot_ctl_t     ctl;
	logic [TW-1:0] dl_new;
	logic [TW-1:0] eff_dl;
	logic [TW-1:0] late;
	logic [15:0]   rep_new;

	assign s_tready   = (state_q == S_IDLE);
	assign accept     = s_tvalid && s_tready;
	assign out_free   = !out_valid_q || m_tready;
	assign done_issue = (rd_cnt_q == CW'(NUM_SLOTS));
	assign s_id_idx   = SW'(s_tdata[3:0]);
	assign s_id_ok    = (32'(s_tdata[3:0]) < NUM_SLOTS) && active_q[s_id_idx];

	assign hit       = ok_q && (idx_s1 == id_q);
	assign alloc     = (action_q == ACT_ADD) && !found_q && !active_q[idx_s1];
	assign emit_fire = (state_q == S_WALK) && v_s1 && ctl.fire && pend_q;
	assign adv       = !(emit_fire && !out_free);
	assign wait_full = (best_q > now_q) ? (best_q - now_q) : '0;

	tsts_slot_unit #(
		.TIME_WIDTH (TW)
	) u_unit (
		.action    (action_q),
		.now       (now_q),
		.in_period (period_q),
		.in_count  (count_q),
		.hit       (hit),
		.alloc     (alloc),
		.active    (active_q[idx_s1]),
		.period    (period_s1),
		.deadline  (dl_s1),
		.repeats   (rep_s1),
		.ctl       (ctl),
		.dl_new    (dl_new),
		.eff_dl    (eff_dl),
		.late      (late),
		.rep_new   (rep_new)
	);

	// memories: read ahead at the walk counter, write at the evaluated slot
	always_ff @(posedge clk) begin
		if (state_q == S_WALK && adv) begin
			if (!done_issue) begin
				period_s1 <= period_mem[rd_cnt_q[SW-1:0]];
				dl_s1     <= deadline_mem[rd_cnt_q[SW-1:0]];
				rep_s1    <= repeats_mem[rd_cnt_q[SW-1:0]];
				idx_s1    <= rd_cnt_q[SW-1:0];
			end
			if (v_s1) begin
				if (ctl.wr_per) begin
					period_mem[idx_s1] <= period_q;
				end
				if (ctl.wr_dl) begin
					deadline_mem[idx_s1] <= dl_new;
				end
				if (ctl.wr_rep) begin
					repeats_mem[idx_s1] <= rep_new;
				end
			end
			dl_s2 <= eff_dl;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= s_tuser;
			id_q     <= s_id_idx;
			count_q  <= s_tdata[19:4];
			period_q <= TW'(s_tdata[51:20]);
			now_q    <= TW'(s_tdata[83:52]);
		end
		if (state_q == S_WALK && adv) begin
			if (v_s1 && alloc) begin
				alloc_slot_q <= idx_s1;
			end
			if (v_s1 && ctl.fire) begin
				pend_slot_q <= 4'(idx_s1);
				pend_late_q <= 32'(late);
			end
			if (v_s2 && act_s2 && (!any_q || dl_s2 < best_q)) begin
				best_q <= dl_s2;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			active_q <= '0;
			ok_q     <= 1'b0;
			rd_cnt_q <= '0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			act_s2   <= 1'b0;
			found_q  <= 1'b0;
			any_q    <= 1'b0;
			pend_q   <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						ok_q     <= s_id_ok;
						rd_cnt_q <= '0;
						v_s1     <= 1'b0;
						v_s2     <= 1'b0;
						found_q  <= 1'b0;
						any_q    <= 1'b0;
						pend_q   <= 1'b0;
						state_q  <= S_WALK;
					end
				end
				S_WALK: begin
					if (adv) begin
						if (!done_issue) begin
							rd_cnt_q <= rd_cnt_q + CW'(1);
						end
						v_s1   <= !done_issue;
						v_s2   <= v_s1;
						act_s2 <= ctl.act_next;
						if (v_s1) begin
							active_q[idx_s1] <= ctl.act_next;
							if (alloc) begin
								found_q <= 1'b1;
							end
							if (ctl.fire) begin
								pend_q <= 1'b1;
							end
						end
						if (v_s2 && act_s2) begin
							any_q <= 1'b1;
						end
						if (done_issue && !v_s1 && !v_s2) begin
							state_q <= S_FIN;
						end
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register: non-final scan results during the walk, final in S_FIN
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((emit_fire && out_free) || (state_q == S_FIN && out_free)) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire && out_free) begin
			o_status_q <= ST_OK;
			o_slot_q   <= pend_slot_q;
			o_fired_q  <= 1'b1;
			o_late_q   <= pend_late_q;
			o_tv_q     <= 1'b0;
			o_next_q   <= '0;
			o_wait_q   <= '0;
			o_last_q   <= 1'b0;
		end else if (state_q == S_FIN && out_free) begin
			case (action_q)
				ACT_ADD: begin
					o_status_q <= found_q ? ST_OK : ST_FULL;
					o_slot_q   <= found_q ? 4'(alloc_slot_q) : 4'd0;
					o_fired_q  <= 1'b0;
					o_late_q   <= '0;
				end
				ACT_REMOVE, ACT_MODIFY: begin
					o_status_q <= ok_q ? ST_OK : ST_INACTIVE;
					o_slot_q   <= '0;
					o_fired_q  <= 1'b0;
					o_late_q   <= '0;
				end
				ACT_SCAN: begin
					o_status_q <= ST_OK;
					o_slot_q   <= pend_q ? pend_slot_q : 4'd0;
					o_fired_q  <= pend_q;
					o_late_q   <= pend_q ? pend_late_q : 32'd0;
				end
				default: begin
					o_status_q <= ST_OK;
					o_slot_q   <= '0;
					o_fired_q  <= 1'b0;
					o_late_q   <= '0;
				end
			endcase
			o_tv_q   <= any_q;
			o_next_q <= any_q ? 32'(best_q) : 32'd0;
			o_wait_q <= any_q ? 32'(wait_full) : 32'd0;
			o_last_q <= 1'b1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, o_wait_q, o_next_q, o_tv_q, o_late_q, o_slot_q};
	assign m_tuser  = {o_fired_q, o_status_q};
	assign m_tlast  = o_last_q;

endmodule

[design/tsts_slot_unit.sv]
module tsts_slot_unit
	import tsts_pkg::*;
#(
	parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
	input  logic [1:0]            action,
	input  logic [TIME_WIDTH-1:0] now,
	input  logic [TIME_WIDTH-1:0] in_period,
	input  logic [15:0]           in_count,
	input  logic                  hit,
	input  logic                  alloc,
	input  logic                  active,
	input  logic [TIME_WIDTH-1:0] period,
	input  logic [TIME_WIDTH-1:0] deadline,
	input  logic [15:0]           repeats,
	output slot_ctl_t             ctl,
	output logic [TIME_WIDTH-1:0] dl_new,
	output logic [TIME_WIDTH-1:0] eff_dl,
	output logic [TIME_WIDTH-1:0] late,
	output logic [15:0]           rep_new
);

	logic [TIME_WIDTH-1:0] opnd;
	logic                  due;

	assign opnd   = (action == ACT_SCAN) ? period : in_period;
	assign dl_new = now + opnd;
	assign late   = now - deadline;
	assign due    = active && !(deadline > now);

	always_comb begin
		ctl          = '0;
		ctl.act_next = active;
		eff_dl       = deadline;
		rep_new      = in_count;
		case (action)
			ACT_ADD: begin
				if (alloc) begin
					ctl.wr_dl    = 1'b1;
					ctl.wr_per   = 1'b1;
					ctl.wr_rep   = 1'b1;
					ctl.act_next = 1'b1;
					eff_dl       = dl_new;
				end
			end
			ACT_REMOVE: begin
				ctl.act_next = active && !hit;
			end
			ACT_MODIFY: begin
				if (hit) begin
					ctl.wr_dl  = 1'b1;
					ctl.wr_per = 1'b1;
					eff_dl     = dl_new;
				end
			end
			ACT_SCAN: begin
				ctl.fire = due;
				if (due) begin
					if (repeats == 16'd0) begin
						ctl.wr_dl = 1'b1;
						eff_dl    = dl_new;
					end else begin
						ctl.wr_rep = 1'b1;
						rep_new    = repeats - 16'd1;
						if (repeats == 16'd1) begin
							ctl.act_next = 1'b0;
						end else begin
							ctl.wr_dl = 1'b1;
							eff_dl    = dl_new;
						end
					end
				end
			end
			default: begin
				ctl.act_next = active;
			end
		endcase
	end

endmodule

[test/tb_timer_slot_table_scan_top.sv]
`timescale 1ns / 100ps

module tb_timer_slot_table_scan_top;
	import tsts_pkg::*;

	localparam int SLOTS = NUM_SLOTS_DEF;
	localparam int RANDOM_CMDS = 450;
	localparam int TAIL_CYCLES = 40;

	typedef struct packed {
		logic [1:0]  action;
		logic [3:0]  slot_id;
		logic [15:0] repeat_count;
		logic [31:0] period_ms;
		logic [31:0] now_ms;
		logic        drain;	// hold until every pending result is back
	} timer_cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  result_slot;
		logic        fired;
		logic [31:0] lateness_ms;
		logic        timeout_valid;
		logic [31:0] next_deadline;
		logic [31:0] wait_ms;
		logic        last;
	} timer_result_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [87:0]  s_tdata = '0;
	logic [1:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [103:0] m_tdata;
	logic [2:0]   m_tuser;
	logic         m_tlast;

	timer_slot_table_scan_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow copy of the slot table
	bit          slot_on  [SLOTS];
	logic [31:0] slot_per [SLOTS];
	logic [31:0] slot_dl  [SLOTS];
	logic [15:0] slot_rep [SLOTS];

	timer_cmd_t    pending_cmds[$];
	timer_result_t expected_results[$];
	timer_cmd_t    cur_cmd;
	int            mismatch_count = 0;

	task automatic apply_timer_command(input timer_cmd_t c);
		timer_result_t r;
		bit          have_fire;
		bit          any;
		logic [31:0] best;
		int          free_slot;

		r = '0;
		have_fire = 0;
		case (c.action)
			ACT_ADD: begin
				free_slot = -1;
				for (int i = 0; i < SLOTS; i++)
					if (!slot_on[i] && free_slot < 0)
						free_slot = i;
				if (free_slot < 0) begin
					r.status = ST_FULL;
				end else begin
					slot_on[free_slot]  = 1;
					slot_per[free_slot] = c.period_ms;
					slot_dl[free_slot]  = c.now_ms + c.period_ms;
					slot_rep[free_slot] = c.repeat_count;
					r.result_slot = free_slot[3:0];
				end
			end
			ACT_REMOVE, ACT_MODIFY: begin
				if (!slot_on[c.slot_id]) begin
					r.status = ST_INACTIVE;
				end else if (c.action == ACT_REMOVE) begin
					slot_on[c.slot_id] = 0;
				end else begin
					slot_per[c.slot_id] = c.period_ms;
					slot_dl[c.slot_id]  = c.now_ms + c.period_ms;
				end
			end
			default: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (slot_on[i] && slot_dl[i] <= c.now_ms) begin
						if (have_fire)
							expected_results.push_back(r);
						have_fire = 1;
						r = '0;
						r.result_slot = i[3:0];
						r.fired = 1'b1;
						r.lateness_ms = c.now_ms - slot_dl[i];
						// zero count repeats forever; otherwise free on the last firing
						if (slot_rep[i] != 0) begin
							slot_rep[i] = slot_rep[i] - 16'd1;
							if (slot_rep[i] == 0)
								slot_on[i] = 0;
						end
						if (slot_on[i])
							slot_dl[i] = c.now_ms + slot_per[i];
					end
				end
			end
		endcase

		any = 0;
		best = '0;
		for (int i = 0; i < SLOTS; i++)
			if (slot_on[i] && (!any || slot_dl[i] < best)) begin
				best = slot_dl[i];
				any = 1;
			end
		r.timeout_valid = any;
		r.next_deadline = best;
		r.wait_ms = (any && best > c.now_ms) ? best - c.now_ms : '0;
		r.last = 1'b1;
		expected_results.push_back(r);
	endtask

	// sender: bursts with random gaps
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
		end else begin
			if (s_tvalid && s_tready)
				apply_timer_command(cur_cmd);
			if (!(s_tvalid && !s_tready)) begin
				if (gap_left != 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pending_cmds.size() == 0 ||
				             (pending_cmds[0].drain && expected_results.size() != 0)) begin
					s_tvalid <= 1'b0;
				end else begin
					cur_cmd = pending_cmds.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {4'b0, cur_cmd.now_ms, cur_cmd.period_ms,
					             cur_cmd.repeat_count, cur_cmd.slot_id};
					s_tuser  <= cur_cmd.action;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 12);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
					end else begin
						burst_left--;
					end
				end
			end
		end
	end

	// receiver: picks a new random stall mode whenever the current one runs out
	int stall_mode = 0;
	int mode_left = 0;
	int tick = 0;

	always @(posedge clk or negedge arst_n) begin
		timer_result_t got;
		timer_result_t exp;

		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = {m_tuser[1:0], m_tdata[3:0], m_tuser[2], m_tdata[35:4], m_tdata[36],
				       m_tdata[68:37], m_tdata[100:69], m_tlast};
				if (expected_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: unexpected result %h", $realtime, got);
				end else begin
					exp = expected_results.pop_front();
					if (got.status !== exp.status || got.result_slot !== exp.result_slot ||
					    got.fired !== exp.fired || got.lateness_ms !== exp.lateness_ms ||
					    got.timeout_valid !== exp.timeout_valid ||
					    got.next_deadline !== exp.next_deadline ||
					    got.wait_ms !== exp.wait_ms || got.last !== exp.last) begin
						mismatch_count++;
						if (mismatch_count <= 10) begin
							$display("%0t: mismatch st/slot/fired/late/tv/next/wait/last", $realtime);
							$display("  exp %0d %0d %0d %h %0d %h %h %0d", exp.status,
							         exp.result_slot, exp.fired, exp.lateness_ms,
							         exp.timeout_valid, exp.next_deadline, exp.wait_ms, exp.last);
							$display("  got %0d %0d %0d %h %0d %h %h %0d", got.status,
							         got.result_slot, got.fired, got.lateness_ms,
							         got.timeout_valid, got.next_deadline, got.wait_ms, got.last);
						end
					end
				end
			end
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 200);
			end else begin
				mode_left--;
			end
			tick++;
			case (stall_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= ($urandom_range(0, 4) == 0);
				default: m_tready <= tick[1];
			endcase
		end
	end

	task automatic queue_cmd(input logic [1:0] act, input logic [3:0] slot,
	                         input logic [15:0] rep, input logic [31:0] per,
	                         input logic [31:0] now, input bit drain);
		timer_cmd_t c;

		c.action = act;
		c.slot_id = slot;
		c.repeat_count = rep;
		c.period_ms = per;
		c.now_ms = now;
		c.drain = drain;
		pending_cmds.push_back(c);
	endtask

	initial begin
		logic [31:0] clock_ms;
		logic [31:0] per;
		logic [15:0] rep;
		logic [1:0]  act;
		int          pick;

		// empty table, inactive slots at both ends
		queue_cmd(ACT_SCAN, 4'd0, 16'd0, 32'd0, 32'd0, 0);
		queue_cmd(ACT_REMOVE, 4'd0, 16'd0, 32'd0, 32'd5, 0);
		queue_cmd(ACT_MODIFY, 4'd15, 16'hFFFF, 32'hFFFF_FFFF, 32'd5, 0);
		// one-shot with zero period, forever with wrapping period, max count, count of two
		queue_cmd(ACT_ADD, 4'd9, 16'd1, 32'd0, 32'd100, 0);
		queue_cmd(ACT_ADD, 4'd0, 16'd0, 32'hFFFF_FFFF, 32'd100, 0);
		queue_cmd(ACT_ADD, 4'd15, 16'hFFFF, 32'd50, 32'd100, 0);
		queue_cmd(ACT_ADD, 4'd3, 16'd2, 32'd10, 32'd100, 0);
		queue_cmd(ACT_SCAN, 4'd0, 16'd0, 32'd0, 32'd100, 0);
		queue_cmd(ACT_MODIFY, 4'd2, 16'd0, 32'd0, 32'd200, 0);
		queue_cmd(ACT_SCAN, 4'd15, 16'd0, 32'd0, 32'hFFFF_FFFF, 0);
		// fill the table, then one add too many, then fire every slot at once
		for (int i = 0; i < 13; i++)
			queue_cmd(ACT_ADD, 4'(i), 16'd1, 32'(i * 7), 32'd0, 0);
		queue_cmd(ACT_ADD, 4'd0, 16'd1, 32'd1, 32'd0, 0);
		queue_cmd(ACT_SCAN, 4'd0, 16'd0, 32'd0, 32'hFFFF_FFFF, 0);

		clock_ms = 32'd1000;
		for (int n = 0; n < RANDOM_CMDS; n++) begin
			if ($urandom_range(0, 49) == 0)
				clock_ms = $urandom;
			else
				clock_ms = clock_ms + $urandom_range(0, 40);
			per = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 120);
			pick = $urandom_range(0, 9);
			rep = (pick < 3) ? 16'd0 : (pick < 8) ? 16'($urandom_range(1, 3)) :
			      16'($urandom_range(0, 65535));
			pick = $urandom_range(0, 99);
			act = (pick < 40) ? ACT_ADD : (pick < 55) ? ACT_REMOVE :
			      (pick < 70) ? ACT_MODIFY : ACT_SCAN;
			queue_cmd(act, 4'($urandom_range(0, 15)), rep, per, clock_ms,
			          (n % 75) == 0);
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_cmds.size() != 0 || s_tvalid)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("tb_timer_slot_table_scan_top: PASS");
		else
			$display("tb_timer_slot_table_scan_top: FAIL");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("tb_timer_slot_table_scan_top: FAIL");
		$finish;
	end

endmodule
